// ===== sv/adaptive_batch_backoff_controller_defines.svh =====
// ----------------------------------------------------------------------------
// adaptive batch backoff controller: assertion macros
// concurrent checks sampled on clk, switched off while rst is high
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_BATCH_BACKOFF_CONTROLLER_DEFINES_SVH
`define ADAPTIVE_BATCH_BACKOFF_CONTROLLER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define ABBC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("abbc: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define ABBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("abbc: next-cycle check failed");

`endif

// ===== sv/abbc_pkg.sv =====
// ----------------------------------------------------------------------------
// abbc_pkg
// shared widths, codes and the queued event record
// ----------------------------------------------------------------------------
`default_nettype none

package abbc_pkg;

  localparam int MAX_BATCH_LIMIT = 256;
  localparam int MIN_BATCH       = 1;
  localparam int HEALTHY_RUN_LEN = 4;
  localparam int QUEUE_DEPTH     = 2;

  localparam int BATCH_W    = 9;
  localparam int STAMP_W    = 64;
  localparam int DELAY_W    = 32;
  localparam int DROP_W     = 32;
  localparam int FILL_W     = 16;
  localparam int COUNT_W    = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic [BATCH_W-1:0] batch_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [DELAY_W-1:0] delay_t;
  typedef logic [DROP_W-1:0]  drop_t;
  typedef logic [FILL_W-1:0]  fill_t;
  typedef logic [COUNT_W-1:0] count_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BATCH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_BATCH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_START    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_MAX      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESYNC_ENABLED = 3'd4;

  // register reset values
  localparam batch_t RST_MAX_BATCH     = 9'd64;
  localparam batch_t RST_INITIAL_BATCH = 9'd16;
  localparam delay_t RST_RETRY_START   = 32'd1000000;
  localparam delay_t RST_RETRY_MAX     = 32'd1000000000;

  typedef enum logic [1:0] {
    CMD_REPORT   = 2'd0,
    CMD_ADMIT    = 2'd1,
    CMD_RESULT   = 2'd2,
    CMD_ACK_LOSS = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    LVL_NORMAL    = 2'd0,
    LVL_NEAR_FULL = 2'd1,
    LVL_FULL      = 2'd2,
    LVL_LOSS      = 2'd3
  } level_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_RETRY      = 3'd1,
    ST_REJECT     = 3'd2,
    ST_BUSY       = 3'd3,
    ST_INCOMPLETE = 3'd4
  } status_t;

  // classified event, as held in the queue between front and back
  typedef struct packed {
    cmd_t   cmd;
    stamp_t now;
    level_t lvl;
    drop_t  drops;
    logic   rs_ok;
    logic   cnt_nz;      // flush carries entries
    logic   half_free;   // fill below half of capacity
    logic   overfill;    // fill plus entries exceeds capacity
    logic   short_done;  // fewer entries done than submitted
    logic   busy;
  } op_t;

endpackage

`default_nettype wire

// ===== sv/abbc_evt_if.sv =====
// ----------------------------------------------------------------------------
// abbc_evt_if
// event channel: valid/ready with the event fields
// ----------------------------------------------------------------------------
`default_nettype none

interface abbc_evt_if;
  import abbc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           command;
  logic [STAMP_W-1:0]   now_ns;
  logic [1:0]           pressure_level;
  logic [FILL_W-1:0]    queue_fill;
  logic [FILL_W-1:0]    queue_capacity;
  logic [DROP_W-1:0]    drop_total;
  logic                 resync_ok;
  logic [COUNT_W-1:0]   flush_entries;
  logic [COUNT_W-1:0]   entries_done;
  logic                 device_busy;

  modport source (
    output valid, command, now_ns, pressure_level, queue_fill, queue_capacity,
           drop_total, resync_ok, flush_entries, entries_done, device_busy,
    input  ready
  );

  modport sink (
    input  valid, command, now_ns, pressure_level, queue_fill, queue_capacity,
           drop_total, resync_ok, flush_entries, entries_done, device_busy,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/abbc_res_if.sv =====
// ----------------------------------------------------------------------------
// abbc_res_if
// result channel: valid/ready with the result fields
// ----------------------------------------------------------------------------
`default_nettype none

interface abbc_res_if;
  import abbc_pkg::*;

  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [BATCH_W-1:0] target_size;
  logic               pressured;
  logic               resync_requested;
  logic               loss_acked;
  logic [STAMP_W-1:0] retry_deadline_ns;

  modport source (
    output valid, status, target_size, pressured, resync_requested, loss_acked,
           retry_deadline_ns,
    input  ready
  );

  modport sink (
    input  valid, status, target_size, pressured, resync_requested, loss_acked,
           retry_deadline_ns,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/adaptive_batch_backoff_controller.sv =====
// ----------------------------------------------------------------------------
// adaptive_batch_backoff_controller
// batch-size adaptation and retry backoff for a device event path
// ----------------------------------------------------------------------------
// The block takes one event per clock while its queue has room and answers
// each with exactly one result. An event is accepted on evt, passes through
// a two-entry queue and is carried out by the back end, whose combinational
// state update sets the sustained rate of one event per cycle while results
// are taken; the result is loaded into an output register when the queue is
// popped and stays there until it is taken on res, while further events keep
// filling the queue. Configuration goes through cfg_we/cfg_index/cfg_data and
// is meant to be written only when no result is outstanding; a write of the
// batch size limit or of the starting batch size reloads the target batch
// size, and a write of retry_start_ns restarts the backoff and clears the
// retry window. There is no clearing pass after reset.
`default_nettype none
`include "adaptive_batch_backoff_controller_defines.svh"

module adaptive_batch_backoff_controller #(
  parameter int HEALTHY_RUN_LEN = abbc_pkg::HEALTHY_RUN_LEN,
  parameter int QUEUE_DEPTH     = abbc_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  abbc_evt_if.sink                        evt,
  abbc_res_if.source                      res,
  input  logic                            cfg_we,
  input  logic [abbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [abbc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import abbc_pkg::*;

  // front to queue
  logic push;
  logic q_full;
  op_t  op_in;

  // queue to back
  logic q_valid;
  logic pop;
  op_t  op_out;

  // front: accept and classify, stalls only when the queue is full
  abbc_front u_front (
    .evt    (evt),
    .q_full (q_full),
    .push   (push),
    .op     (op_in)
  );

  // queue: lets the front keep taking transfers while a result waits
  abbc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (op_in),
    .full    (q_full),
    .pop     (pop),
    .valid   (q_valid),
    .rd_data (op_out)
  );

  // back: state update and result register, pops when the register frees
  abbc_back #(
    .HEALTHY_RUN_LEN (HEALTHY_RUN_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .op        (op_out),
    .pop       (pop),
    .res       (res)
  );

  // an accepted transfer must be waiting in the queue next cycle
  `ABBC_ASSERT_NEXT(a_push_lands, evt.valid && evt.ready, q_valid)

  // a retry window rejection needs a live deadline
  `ABBC_ASSERT_SAME(a_retry_has_deadline, res.valid && (res.status == ST_RETRY),
                    res.retry_deadline_ns != '0)

  // arming the backoff always leaves a non-zero deadline
  `ABBC_ASSERT_SAME(a_arm_has_deadline,
                    res.valid && ((res.status == ST_REJECT) || (res.status == ST_BUSY)),
                    res.retry_deadline_ns != '0)

  // a resync is only requested for a report judged as pressure
  `ABBC_ASSERT_SAME(a_resync_under_pressure, res.valid && res.resync_requested,
                    res.pressured)

  // the target never drops below the minimum batch size
  `ABBC_ASSERT_SAME(a_target_floor, res.valid,
                    res.target_size >= BATCH_W'(MIN_BATCH))
endmodule

`default_nettype wire

// ===== sv/abbc_front.sv =====
// ----------------------------------------------------------------------------
// abbc_front
// accepts events and reduces the device fields to a queued event record
// ----------------------------------------------------------------------------
`default_nettype none

module abbc_front (
  abbc_evt_if.sink       evt,
  input  logic           q_full,
  output logic           push,
  output abbc_pkg::op_t  op
);
  import abbc_pkg::*;

  logic [FILL_W:0] fill_sum;

  assign evt.ready = !q_full;
  assign push      = evt.valid && !q_full;

  // queued records plus the flush, one bit of headroom
  assign fill_sum = {1'b0, evt.queue_fill}
                  + {{(FILL_W + 1 - COUNT_W){1'b0}}, evt.flush_entries};

  always_comb begin
    op.cmd        = cmd_t'(evt.command);
    op.now        = evt.now_ns;
    op.lvl        = level_t'(evt.pressure_level);
    op.drops      = evt.drop_total;
    op.rs_ok      = evt.resync_ok;
    op.cnt_nz     = (evt.flush_entries != '0);
    op.half_free  = (evt.queue_fill < (evt.queue_capacity >> 1));
    op.overfill   = (fill_sum > {1'b0, evt.queue_capacity});
    // clamping done to count leaves a shortfall exactly when done < count
    op.short_done = (evt.entries_done < evt.flush_entries);
    op.busy       = evt.device_busy;
  end
endmodule

`default_nettype wire

// ===== sv/abbc_queue.sv =====
// ----------------------------------------------------------------------------
// abbc_queue
// short event queue decoupling the front from the back
// ----------------------------------------------------------------------------
`default_nettype none

module abbc_queue #(
  parameter int DEPTH = abbc_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  abbc_pkg::op_t  wr_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output abbc_pkg::op_t  rd_data
);
  import abbc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end
endmodule

`default_nettype wire

// ===== sv/abbc_back.sv =====
// ----------------------------------------------------------------------------
// abbc_back
// configuration, controller state update and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module abbc_back #(
  parameter int HEALTHY_RUN_LEN = abbc_pkg::HEALTHY_RUN_LEN
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [abbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [abbc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           q_valid,
  input  abbc_pkg::op_t                  op,
  output logic                           pop,
  abbc_res_if.source                     res
);
  import abbc_pkg::*;

  localparam int RUN_W = $clog2(HEALTHY_RUN_LEN + 1);
  localparam batch_t BATCH_CEIL  = (MAX_BATCH_LIMIT > 511) ? 9'd511
                                                         : BATCH_W'(MAX_BATCH_LIMIT);
  localparam batch_t BATCH_FLOOR = BATCH_W'(MIN_BATCH);

  function automatic batch_t eff_max(input batch_t mb);
    batch_t m;
    m = (mb > BATCH_CEIL) ? BATCH_CEIL : mb;
    if (m < BATCH_FLOOR) m = BATCH_FLOOR;
    return m;
  endfunction

  function automatic batch_t bound_size(input batch_t v, input batch_t m);
    if (v < BATCH_FLOOR) return BATCH_FLOOR;
    if (v > m) return m;
    return v;
  endfunction

  function automatic stamp_t arm_deadline(input stamp_t now, input delay_t d);
    logic [STAMP_W:0] sum;
    sum = {1'b0, now} + {{(STAMP_W + 1 - DELAY_W){1'b0}}, d};
    return sum[STAMP_W] ? '1 : sum[STAMP_W-1:0];
  endfunction

  function automatic delay_t arm_delay(input delay_t d, input delay_t rmax);
    return (d >= (rmax >> 1)) ? rmax : {d[DELAY_W-2:0], 1'b0};
  endfunction

  // configuration registers
  batch_t batch_cap;
  batch_t batch_seed;
  delay_t retry_start;
  delay_t retry_max;
  logic   resync_enabled;

  // controller state
  batch_t           target_size_reg, target_size_next;
  logic [RUN_W-1:0] healthy_run, healthy_run_next;
  drop_t            drop_watermark, drop_watermark_next;
  logic             loss_ack_flag, loss_ack_flag_next;
  stamp_t           retry_deadline, retry_deadline_next;
  delay_t           backoff_delay, backoff_delay_next;

  // result register
  logic    out_valid;
  status_t status_next;
  logic    pressured_next;
  logic    resync_next;

  batch_t m_eff;
  delay_t start_eff;
  logic   in_window;
  logic   judge_en;

  assign m_eff     = eff_max(batch_cap);
  assign start_eff = (retry_start != '0) ? retry_start : DELAY_W'(1);
  assign in_window = (op.now != '0) && (retry_deadline > op.now);
  assign judge_en  = (op.cmd == CMD_REPORT)
                  || ((op.cmd == CMD_ADMIT) && op.cnt_nz && !in_window);
  assign pop       = q_valid && (!out_valid || res.ready);

  always_comb begin
    logic p;
    delay_t d;
    target_size_next    = target_size_reg;
    healthy_run_next    = healthy_run;
    drop_watermark_next = drop_watermark;
    loss_ack_flag_next  = loss_ack_flag;
    retry_deadline_next = retry_deadline;
    backoff_delay_next  = backoff_delay;
    status_next         = ST_OK;
    pressured_next      = 1'b0;
    resync_next         = 1'b0;
    p                   = 1'b0;
    d                   = '0;

    // judge the carried report
    if (judge_en) begin
      if (op.drops > drop_watermark_next) begin
        drop_watermark_next = op.drops;
        loss_ack_flag_next  = 1'b0;
        p                   = 1'b1;
      end
      if ((op.lvl == LVL_NEAR_FULL) || (op.lvl == LVL_FULL)
          || ((op.lvl == LVL_LOSS) && !loss_ack_flag_next)) begin
        p = 1'b1;
      end
      if (p) begin
        if ((op.lvl == LVL_LOSS) && !loss_ack_flag_next && resync_enabled) begin
          resync_next = 1'b1;
          if (op.rs_ok) loss_ack_flag_next = 1'b1;
        end
        target_size_next = bound_size(target_size_next >> 1, m_eff);
        healthy_run_next = '0;
      end else if ((op.lvl == LVL_NORMAL) && op.half_free) begin
        if (healthy_run_next < RUN_W'(HEALTHY_RUN_LEN)) begin
          healthy_run_next = healthy_run_next + RUN_W'(1);
        end
        if ((healthy_run_next >= RUN_W'(HEALTHY_RUN_LEN))
            && (target_size_next < m_eff)) begin
          target_size_next = bound_size((target_size_next > (m_eff >> 1))
                                        ? m_eff : {target_size_next[BATCH_W-2:0], 1'b0},
                                        m_eff);
          healthy_run_next = '0;
        end
      end else begin
        healthy_run_next = '0;
        if (loss_ack_flag_next) begin
          retry_deadline_next = '0;
          backoff_delay_next  = start_eff;
        end
      end
      pressured_next = p;
    end

    case (op.cmd)
      CMD_REPORT: begin
      end
      CMD_ADMIT: begin
        if (op.cnt_nz) begin
          if (in_window) begin
            status_next = ST_RETRY;
          end else if (((op.lvl == LVL_LOSS) && !loss_ack_flag_next)
                       || (op.lvl == LVL_FULL) || op.overfill) begin
            status_next         = ST_REJECT;
            d                   = (backoff_delay_next != '0) ? backoff_delay_next : start_eff;
            retry_deadline_next = arm_deadline(op.now, d);
            backoff_delay_next  = arm_delay(d, retry_max);
          end
        end
      end
      CMD_RESULT: begin
        if (op.cnt_nz) begin
          if (op.busy) begin
            target_size_next    = bound_size(target_size_next >> 1, m_eff);
            healthy_run_next    = '0;
            d                   = (backoff_delay_next != '0) ? backoff_delay_next : start_eff;
            retry_deadline_next = arm_deadline(op.now, d);
            backoff_delay_next  = arm_delay(d, retry_max);
            status_next         = ST_BUSY;
          end else if (op.short_done) begin
            status_next = ST_INCOMPLETE;
          end else begin
            retry_deadline_next = '0;
            backoff_delay_next  = start_eff;
          end
        end
      end
      CMD_ACK_LOSS: begin
        loss_ack_flag_next  = 1'b1;
        healthy_run_next    = '0;
        retry_deadline_next = '0;
        backoff_delay_next  = start_eff;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_cap       <= RST_MAX_BATCH;
      batch_seed      <= RST_INITIAL_BATCH;
      retry_start     <= RST_RETRY_START;
      retry_max       <= RST_RETRY_MAX;
      resync_enabled  <= 1'b0;
      target_size_reg <= bound_size(RST_INITIAL_BATCH, eff_max(RST_MAX_BATCH));
      healthy_run     <= '0;
      drop_watermark  <= '0;
      loss_ack_flag   <= 1'b0;
      retry_deadline  <= '0;
      backoff_delay   <= RST_RETRY_START;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_BATCH: begin
            batch_cap       <= cfg_data[BATCH_W-1:0];
            target_size_reg <= bound_size(batch_seed, eff_max(cfg_data[BATCH_W-1:0]));
          end
          REG_INITIAL_BATCH: begin
            batch_seed      <= cfg_data[BATCH_W-1:0];
            target_size_reg <= bound_size(cfg_data[BATCH_W-1:0], m_eff);
          end
          REG_RETRY_START: begin
            retry_start    <= cfg_data[DELAY_W-1:0];
            backoff_delay  <= (cfg_data[DELAY_W-1:0] != '0) ? cfg_data[DELAY_W-1:0]
                                                            : DELAY_W'(1);
            retry_deadline <= '0;
          end
          REG_RETRY_MAX: begin
            retry_max <= cfg_data[DELAY_W-1:0];
          end
          REG_RESYNC_ENABLED: begin
            resync_enabled <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end else if (pop) begin
        target_size_reg <= target_size_next;
        healthy_run     <= healthy_run_next;
        drop_watermark  <= drop_watermark_next;
        loss_ack_flag   <= loss_ack_flag_next;
        retry_deadline  <= retry_deadline_next;
        backoff_delay   <= backoff_delay_next;
      end

      if (pop) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.status            <= status_next;
      res.target_size       <= target_size_next;
      res.pressured         <= pressured_next;
      res.resync_requested  <= resync_next;
      res.loss_acked        <= loss_ack_flag_next;
      res.retry_deadline_ns <= retry_deadline_next;
    end
  end

  assign res.valid = out_valid;
endmodule

`default_nettype wire

// ===== verif/tb_adaptive_batch_backoff_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_batch_backoff_controller
// self-checking bench: directed table then random event traffic over several
// register settings, each result compared with a typed-in outcome or with the in-bench predictor
// ----------------------------------------------------------------------------
module tb_adaptive_batch_backoff_controller;
  import abbc_pkg::*;

  // no-transfer cycles tolerated before the run is declared hung; the worst
  // legal stretch is a long source gap plus a long sink stall, well below this
  localparam int STALL_LIMIT = 2000;
  // cycles of sink hold-off used to fill the block and stall its input
  localparam int HOLD_CYCLES = 60;

  // one event as driven on the event channel
  typedef struct {
    cmd_t   cmd;
    stamp_t now;
    level_t lvl;
    fill_t  fill;
    fill_t  cap;
    drop_t  drops;
    logic   rs_ok;
    count_t cnt;
    count_t done;
    logic   busy;
  } event_t;

  // one result as seen on the result channel
  typedef struct {
    status_t status;
    batch_t  target;
    logic    pressured;
    logic    resync_req;
    logic    loss_acked;
    stamp_t  deadline;
  } result_t;

  // directed row: the outcome is typed in where it is obvious, otherwise
  // the predictor supplies it
  typedef struct {
    event_t  ev;
    bit      known;
    result_t want;
  } row_t;

  typedef struct {
    batch_t max;
    batch_t init;
    delay_t start;
    delay_t ceiling;
    logic   resync;
  } setting_t;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  abbc_evt_if evt_ch ();
  abbc_res_if res_ch ();

  adaptive_batch_backoff_controller DUT (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // predictor: register copies and controller state
  // --------------------------------------------------------------------------
  batch_t cfg_max, cfg_init;
  delay_t cfg_start, cfg_ceiling;
  logic   cfg_resync;

  batch_t m_target;
  int     m_streak;
  drop_t  m_drop_mark;
  logic   m_loss_acked;
  stamp_t m_deadline;
  delay_t m_delay;

  result_t pending_outcomes[$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  bit      calm = 1'b0;          // no idling on either side while set
  bit      hold_request = 1'b0;  // asks the sink for one long hold-off
  stamp_t  mono_ns = 64'd0;      // running time base for random events
  drop_t   last_drops = '0;      // cumulative drop count as last reported

  // size limit register saturated into the legal batch range
  function automatic int size_ceiling();
    int m;
    m = int'(cfg_max);
    if (m > MAX_BATCH_LIMIT) m = MAX_BATCH_LIMIT;
    if (m < MIN_BATCH) m = MIN_BATCH;
    return m;
  endfunction

  function automatic batch_t clamp_size(int v);
    int m;
    m = size_ceiling();
    if (v < MIN_BATCH) return batch_t'(MIN_BATCH);
    if (v > m) return batch_t'(m);
    return batch_t'(v);
  endfunction

  // a zero start delay behaves as one
  function automatic delay_t start_delay();
    return (cfg_start != 0) ? cfg_start : delay_t'(1);
  endfunction

  function automatic void clear_backoff();
    m_deadline = '0;
    m_delay    = start_delay();
  endfunction

  // deadline saturates at all ones; delay doubles up to the ceiling
  function automatic void arm_backoff(stamp_t now);
    delay_t d;
    d = (m_delay != 0) ? m_delay : start_delay();
    if (now > (64'hFFFF_FFFF_FFFF_FFFF - stamp_t'(d))) m_deadline = '1;
    else m_deadline = now + stamp_t'(d);
    if (d >= cfg_ceiling / 2) m_delay = cfg_ceiling;
    else m_delay = d * 2;
  endfunction

  function automatic void shrink();
    m_target = clamp_size(int'(m_target) / 2);
    m_streak = 0;
  endfunction

  function automatic void grow();
    int m, nx;
    m = size_ceiling();
    if (int'(m_target) >= m) return;
    nx = (int'(m_target) > m / 2) ? m : int'(m_target) * 2;
    m_target = clamp_size(nx);
    m_streak = 0;
  endfunction

  // pressure judgement shared by reports and admissions
  function automatic void judge_report(event_t e, output logic pr, output logic rq);
    bit p;
    p  = 1'b0;
    rq = 1'b0;
    if (e.drops > m_drop_mark) begin
      m_drop_mark  = e.drops;
      m_loss_acked = 1'b0;
      p            = 1'b1;
    end
    if (e.lvl == LVL_NEAR_FULL || e.lvl == LVL_FULL || (e.lvl == LVL_LOSS && !m_loss_acked))
      p = 1'b1;
    if (p) begin
      if (e.lvl == LVL_LOSS && !m_loss_acked && cfg_resync) begin
        rq = 1'b1;
        if (e.rs_ok) m_loss_acked = 1'b1;
      end
      shrink();
    end else if (e.lvl == LVL_NORMAL && int'(e.fill) < int'(e.cap) / 2) begin
      if (m_streak < HEALTHY_RUN_LEN) m_streak++;
      if (m_streak >= HEALTHY_RUN_LEN) grow();
    end else begin
      m_streak = 0;
      if (m_loss_acked) clear_backoff();
    end
    pr = p;
  endfunction

  // applies one event to the controller copy and returns its result
  function automatic result_t advance_controller(event_t e);
    status_t st;
    logic    pr, rq;
    count_t  done;
    st = ST_OK;
    pr = 1'b0;
    rq = 1'b0;
    case (e.cmd)
      CMD_REPORT: judge_report(e, pr, rq);
      CMD_ADMIT: begin
        if (e.cnt != 0) begin
          if (e.now != 0 && m_deadline > e.now) begin
            st = ST_RETRY;
          end else begin
            judge_report(e, pr, rq);
            if ((e.lvl == LVL_LOSS && !m_loss_acked) || e.lvl == LVL_FULL ||
                int'(e.fill) + int'(e.cnt) > int'(e.cap)) begin
              st = ST_REJECT;
              arm_backoff(e.now);
            end
          end
        end
      end
      CMD_RESULT: begin
        if (e.cnt != 0) begin
          done = (e.done > e.cnt) ? e.cnt : e.done;
          if (e.busy) begin
            shrink();
            arm_backoff(e.now);
            st = ST_BUSY;
          end else if (done < e.cnt) begin
            st = ST_INCOMPLETE;
          end else begin
            clear_backoff();
          end
        end
      end
      default: begin
        m_loss_acked = 1'b1;
        m_streak     = 0;
        clear_backoff();
      end
    endcase
    return '{st, m_target, pr, rq, m_loss_acked, m_deadline};
  endfunction

  function automatic void load_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_MAX_BATCH: begin
        cfg_max  = data[BATCH_W-1:0];
        m_target = clamp_size(int'(cfg_init));
      end
      REG_INITIAL_BATCH: begin
        cfg_init = data[BATCH_W-1:0];
        m_target = clamp_size(int'(cfg_init));
      end
      REG_RETRY_START: begin
        cfg_start = data;
        clear_backoff();
      end
      REG_RETRY_MAX:      cfg_ceiling = data;
      REG_RESYNC_ENABLED: cfg_resync = data[0];
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic event_t make_event(cmd_t c, stamp_t now, level_t l, fill_t f, fill_t cap,
                                        drop_t d, logic rs, count_t n, count_t dn, logic b);
    event_t e;
    e = '{c, now, l, f, cap, d, rs, n, dn, b};
    return e;
  endfunction

  function automatic row_t calc(event_t e);
    row_t r;
    r.ev    = e;
    r.known = 1'b0;
    r.want  = '{ST_OK, '0, 1'b0, 1'b0, 1'b0, '0};
    return r;
  endfunction

  function automatic row_t known(event_t e, result_t w);
    row_t r;
    r.ev    = e;
    r.known = 1'b1;
    r.want  = w;
    return r;
  endfunction

  // moves the time base on by anything from nothing to a big jump
  function automatic stamp_t next_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20)      mono_ns += 0;
    else if (r < 45) mono_ns += $urandom_range(0, 64);
    else if (r < 70) mono_ns += $urandom_range(0, 4096);
    else if (r < 95) mono_ns += $urandom_range(0, 2000000);
    else             mono_ns += $urandom;
    return mono_ns;
  endfunction

  // half-empty normal report at an unchanged drop count
  function automatic event_t healthy_report();
    fill_t cap;
    cap = ($urandom_range(0, 3) == 0) ? fill_t'($urandom_range(2, 65535))
                                      : fill_t'($urandom_range(2, 1000));
    return make_event(CMD_REPORT, next_time(), LVL_NORMAL,
                      fill_t'($urandom_range(0, int'(cap) / 2 - 1)), cap, last_drops,
                      1'($urandom_range(0, 1)), count_t'($urandom_range(0, 511)),
                      count_t'($urandom_range(0, 511)), 1'($urandom_range(0, 1)));
  endfunction

  function automatic event_t random_event();
    event_t e;
    int     r;
    r = $urandom_range(0, 99);
    if (r < 45)      e.cmd = CMD_REPORT;
    else if (r < 70) e.cmd = CMD_ADMIT;
    else if (r < 90) e.cmd = CMD_RESULT;
    else             e.cmd = CMD_ACK_LOSS;

    r = $urandom_range(0, 99);
    if (r < 80)      e.now = next_time();
    else if (r < 87) e.now = '0;
    else if (r < 94) e.now = {$urandom, $urandom};
    else             e.now = 64'hFFFF_FFFF_FFFF_FFFF - stamp_t'($urandom_range(0, 1000));

    r = $urandom_range(0, 99);
    if (r < 50)      e.lvl = LVL_NORMAL;
    else if (r < 62) e.lvl = LVL_NEAR_FULL;
    else if (r < 74) e.lvl = LVL_FULL;
    else             e.lvl = LVL_LOSS;

    e.cap = ($urandom_range(0, 3) == 0) ? fill_t'($urandom_range(0, 65535))
                                        : fill_t'($urandom_range(0, 1000));
    r = $urandom_range(0, 99);
    if (r < 55 && e.cap >= 2) e.fill = fill_t'($urandom_range(0, int'(e.cap) / 2 - 1));
    else if (r < 85)          e.fill = fill_t'($urandom_range(0, int'(e.cap)));
    else                      e.fill = fill_t'($urandom_range(0, 65535));

    // drop count mostly steady, sometimes creeping up, rarely anything at all
    r = $urandom_range(0, 99);
    if (r < 65)      e.drops = last_drops;
    else if (r < 90) e.drops = last_drops + $urandom_range(1, 50);
    else if (r < 95) e.drops = $urandom;
    else             e.drops = '0;
    last_drops = e.drops;

    e.rs_ok = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 10)      e.cnt = '0;
    else if (r < 20) e.cnt = count_t'(256);
    else if (r < 25) e.cnt = count_t'($urandom_range(257, 511));
    else             e.cnt = count_t'($urandom_range(1, 255));

    r = $urandom_range(0, 99);
    if (r < 50)      e.done = e.cnt;
    else if (r < 75) e.done = count_t'($urandom_range(0, int'(e.cnt)));
    else             e.done = count_t'($urandom_range(0, 511));
    e.busy = ($urandom_range(0, 3) == 0);
    return e;
  endfunction

  // --------------------------------------------------------------------------
  // source side
  // --------------------------------------------------------------------------
  // offers one event, holds it until the transfer, then records its outcome
  task automatic send_event(event_t e, bit is_known, result_t want);
    int      gap;
    result_t outcome;
    gap = pick_gap();
    if (gap > 0) begin
      evt_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    evt_ch.valid          <= 1'b1;
    evt_ch.command        <= e.cmd;
    evt_ch.now_ns         <= e.now;
    evt_ch.pressure_level <= e.lvl;
    evt_ch.queue_fill     <= e.fill;
    evt_ch.queue_capacity <= e.cap;
    evt_ch.drop_total     <= e.drops;
    evt_ch.resync_ok      <= e.rs_ok;
    evt_ch.flush_entries  <= e.cnt;
    evt_ch.entries_done   <= e.done;
    evt_ch.device_busy    <= e.busy;
    @(posedge clk);
    while (!evt_ch.ready) @(posedge clk);
    outcome = advance_controller(e);
    pending_outcomes.push_back(is_known ? want : outcome);
  endtask

  // withdraws the source and waits for every outstanding result, then lets
  // the back end settle
  task automatic drain_results(int settle);
    evt_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_outcomes.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // register writes on consecutive cycles, only while the block is idle
  task automatic configure(setting_t s, logic [4:0] mask);
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    for (int i = 0; i < 5; i++) begin
      idx = CFG_IDX_W'(i);
      case (idx)
        REG_MAX_BATCH:      val = CFG_DATA_W'(s.max);
        REG_INITIAL_BATCH:  val = CFG_DATA_W'(s.init);
        REG_RETRY_START:    val = s.start;
        REG_RETRY_MAX:      val = s.ceiling;
        default:            val = CFG_DATA_W'(s.resync);
      endcase
      if (mask[i]) begin
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        load_register(idx, val);
      end
    end
    cfg_we <= 1'b0;
  endtask

  // mostly random events, with runs of healthy reports mixed in so that the
  // doubling path is reached and sometimes broken off part way
  task automatic run_random(int count);
    int      k, len;
    result_t blank;
    blank = '{ST_OK, '0, 1'b0, 1'b0, 1'b0, '0};
    k = 0;
    while (k < count) begin
      if ($urandom_range(0, 99) < 12) begin
        len = $urandom_range(2, 6);
        repeat (len) send_event(healthy_report(), 1'b0, blank);
        k += len;
      end else begin
        send_event(random_event(), 1'b0, blank);
        k++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // sink side: random stalls, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : sink_drive
    int stall_left, hold_left;
    stall_left   = 0;
    hold_left    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // each result transfer is checked field by field against the oldest outcome
  always @(posedge clk) begin : result_check
    result_t got, want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{status_t'(res_ch.status), res_ch.target_size, res_ch.pressured,
              res_ch.resync_requested, res_ch.loss_acked, res_ch.retry_deadline_ns};
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with nothing outstanding", 64'(got.status), '0);
      end else begin
        want = pending_outcomes.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.target !== want.target)
          report_mismatch("target_size", 64'(got.target), 64'(want.target));
        if (got.pressured !== want.pressured)
          report_mismatch("pressured", 64'(got.pressured), 64'(want.pressured));
        if (got.resync_req !== want.resync_req)
          report_mismatch("resync_requested", 64'(got.resync_req), 64'(want.resync_req));
        if (got.loss_acked !== want.loss_acked)
          report_mismatch("loss_acked", 64'(got.loss_acked), 64'(want.loss_acked));
        if (got.deadline !== want.deadline)
          report_mismatch("retry_deadline_ns", got.deadline, want.deadline);
      end
    end
  end

  // hang detection: any transfer on either channel restarts the count
  always @(posedge clk) begin
    if (rst || (evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    row_t     directed[$];
    setting_t phases[6];

    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    evt_ch.valid          = 1'b0;
    evt_ch.command        = CMD_REPORT;
    evt_ch.now_ns         = '0;
    evt_ch.pressure_level = LVL_NORMAL;
    evt_ch.queue_fill     = '0;
    evt_ch.queue_capacity = '0;
    evt_ch.drop_total     = '0;
    evt_ch.resync_ok      = 1'b0;
    evt_ch.flush_entries  = '0;
    evt_ch.entries_done   = '0;
    evt_ch.device_busy    = 1'b0;

    // predictor starts from the register reset values
    cfg_max      = RST_MAX_BATCH;
    cfg_init     = RST_INITIAL_BATCH;
    cfg_start    = RST_RETRY_START;
    cfg_ceiling  = RST_RETRY_MAX;
    cfg_resync   = 1'b0;
    m_target     = clamp_size(int'(cfg_init));
    m_streak     = 0;
    m_drop_mark  = '0;
    m_loss_acked = 1'b0;
    m_deadline   = '0;
    m_delay      = cfg_start;

    // directed events at reset settings: target 16, start delay 1 ms
    directed.push_back(known(make_event(CMD_REPORT, 64'd100, LVL_NORMAL, 16'd0, 16'd100, '0,
                             1'b0, 9'd0, 9'd0, 1'b0),
                             '{ST_OK, 9'd16, 1'b0, 1'b0, 1'b0, 64'd0}));
    // loss acknowledgement sets the flag and clears the window
    directed.push_back(known(make_event(CMD_ACK_LOSS, 64'd200, LVL_NORMAL, 16'd0, 16'd0, '0,
                             1'b0, 9'd0, 9'd0, 1'b0),
                             '{ST_OK, 9'd16, 1'b0, 1'b0, 1'b1, 64'd0}));
    // empty flush is a no-op
    directed.push_back(known(make_event(CMD_ADMIT, 64'd300, LVL_FULL, 16'd0, 16'd0, '0,
                             1'b0, 9'd0, 9'd0, 1'b0),
                             '{ST_OK, 9'd16, 1'b0, 1'b0, 1'b1, 64'd0}));
    // busy device: halve and open a window of the start delay
    directed.push_back(known(make_event(CMD_RESULT, 64'd1000, LVL_NORMAL, 16'd0, 16'd0, '0,
                             1'b0, 9'd5, 9'd5, 1'b1),
                             '{ST_BUSY, 9'd8, 1'b0, 1'b0, 1'b1, 64'd1001000}));
    // admission inside the window
    directed.push_back(known(make_event(CMD_ADMIT, 64'd2000, LVL_NORMAL, 16'd0, 16'd100, '0,
                             1'b0, 9'd1, 9'd0, 1'b0),
                             '{ST_RETRY, 9'd8, 1'b0, 1'b0, 1'b1, 64'd1001000}));
    // unknown time never hits the window; the carried report counts as healthy
    directed.push_back(calc(make_event(CMD_ADMIT, 64'd0, LVL_NORMAL, 16'd0, 16'd100, '0,
                            1'b0, 9'd1, 9'd0, 1'b0)));
    // three more healthy reports complete the run and double the target
    repeat (3)
      directed.push_back(calc(make_event(CMD_REPORT, 64'd3000, LVL_NORMAL, 16'd49, 16'd100, '0,
                              1'b1, 9'd0, 9'd0, 1'b0)));
    // fill exactly at half is not healthy
    directed.push_back(calc(make_event(CMD_REPORT, 64'd3100, LVL_NORMAL, 16'd50, 16'd100, '0,
                            1'b0, 9'd0, 9'd0, 1'b0)));
    // new drops at the top of the range clear the loss flag
    directed.push_back(calc(make_event(CMD_REPORT, 64'd4000, LVL_LOSS, 16'hFFFF, 16'hFFFF,
                            32'hFFFF_FFFF, 1'b1, 9'd0, 9'd0, 1'b0)));
    // full device at the last representable time: deadline saturates
    directed.push_back(calc(make_event(CMD_ADMIT, 64'hFFFF_FFFF_FFFF_FFFF, LVL_FULL, 16'hFFFF,
                            16'hFFFF, 32'hFFFF_FFFF, 1'b0, 9'd256, 9'd256, 1'b1)));
    directed.push_back(calc(make_event(CMD_ADMIT, 64'hFFFF_FFFF_FFFF_FFFE, LVL_NORMAL, 16'd0,
                            16'd100, 32'hFFFF_FFFF, 1'b0, 9'd1, 9'd0, 1'b0)));
    // completed count above the flush size is clamped; success clears backoff
    directed.push_back(calc(make_event(CMD_RESULT, 64'd5000, LVL_NORMAL, 16'd0, 16'd0,
                            32'hFFFF_FFFF, 1'b0, 9'd256, 9'd511, 1'b0)));
    // shortfall answers incomplete
    directed.push_back(calc(make_event(CMD_RESULT, 64'd5100, LVL_NORMAL, 16'd0, 16'd0,
                            32'hFFFF_FFFF, 1'b0, 9'd100, 9'd99, 1'b0)));
    // no room for the flush
    directed.push_back(calc(make_event(CMD_ADMIT, 64'd6000, LVL_NORMAL, 16'd60000, 16'd60100,
                            32'hFFFF_FFFF, 1'b0, 9'd200, 9'd0, 1'b0)));
    directed.push_back(calc(make_event(CMD_REPORT, 64'd7000, LVL_NEAR_FULL, 16'd10, 16'd20,
                            32'hFFFF_FFFF, 1'b0, 9'd0, 9'd0, 1'b0)));
    directed.push_back(calc(make_event(CMD_ACK_LOSS, 64'd8000, LVL_LOSS, 16'd0, 16'd0,
                            32'hFFFF_FFFF, 1'b0, 9'd0, 9'd0, 1'b0)));
    // loss already acknowledged: not pressure, backoff cleared
    directed.push_back(calc(make_event(CMD_REPORT, 64'd9000, LVL_LOSS, 16'd5, 16'd6,
                            32'hFFFF_FFFF, 1'b0, 9'd0, 9'd0, 1'b0)));
    directed.push_back(calc(make_event(CMD_RESULT, 64'd9500, LVL_NORMAL, 16'd0, 16'd0,
                            32'hFFFF_FFFF, 1'b0, 9'd0, 9'd0, 1'b1)));
    // lower drop count with loss acknowledged: not pressure, admitted
    directed.push_back(calc(make_event(CMD_ADMIT, 64'd10000, LVL_LOSS, 16'd0, 16'd1000,
                            32'd5, 1'b1, 9'd1, 9'd0, 1'b0)));
    directed.push_back(calc(make_event(CMD_ADMIT, 64'd10001, LVL_NORMAL, 16'd0, 16'd1000,
                            32'd5, 1'b0, 9'd1, 9'd0, 1'b0)));

    // settings walked by the random part; limits, zero delays and the
    // widest values all appear
    phases[0] = '{9'd256, 9'd1,   32'd1,          32'hFFFF_FFFF, 1'b1};
    phases[1] = '{9'd1,   9'd256, 32'd0,          32'd0,         1'b0};
    phases[2] = '{9'd511, 9'd0,   32'hFFFF_FFFF,  32'd1,         1'b1};
    phases[3] = '{9'd0,   9'd300, 32'd1000,       32'd5000,      1'b1};
    phases[4] = '{batch_t'($urandom_range(1, 300)), batch_t'($urandom_range(0, 511)),
                  delay_t'($urandom_range(1, 100000)), delay_t'($urandom), 1'b1};
    phases[5] = '{RST_MAX_BATCH, RST_INITIAL_BATCH, RST_RETRY_START, RST_RETRY_MAX, 1'b0};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_event(directed[i].ev, directed[i].known, directed[i].want);

    last_drops = 32'd5;
    mono_ns    = 64'd20000;
    foreach (phases[p]) begin
      drain_results(4);
      configure(phases[p], (p == 4) ? 5'($urandom_range(1, 31)) : 5'b11111);
      calm = (p == 3);
      if (p == 1) begin
        run_random(20);
        // sink holds off while the source keeps offering: queue fills, input stalls
        hold_request = 1'b1;
        run_random(65);
      end else if (p == 2) begin
        run_random(40);
        // source waits until every result is back before going on
        drain_results(0);
        run_random(45);
      end else begin
        run_random(85);
      end
    end
    calm = 1'b0;

    drain_results(8);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== adaptive_batch_backoff_controller.f =====
+incdir+sv
sv/abbc_pkg.sv
sv/abbc_evt_if.sv
sv/abbc_res_if.sv
sv/abbc_front.sv
sv/abbc_queue.sv
sv/abbc_back.sv
sv/adaptive_batch_backoff_controller.sv
verif/tb_adaptive_batch_backoff_controller.sv
